>>> rtl/core/hvn_pkg.sv
`default_nettype none
package hvn_pkg;

   // Q1.14 unit length
   localparam int ONE_Q14 = 16384;
   // triangle normal z in Q8.8 height units (two grid units squared times 2^7)
   localparam int TRI_Z = 512;

   // operand of the normalizer: triangle normal or per-vertex sum
   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [17:0] z;
   } vec_type;

   // normalized vector, Q1.14
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } nrm_type;

endpackage
`default_nettype wire

>>> rtl/core/hvn_rowbuf.sv
`default_nettype none
module hvn_rowbuf #(
   parameter int DEPTH = 1024,
   parameter int AW = 10
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [15:0]        rd_older,
   output logic [15:0]        rd_prev,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [15:0]   wr_older,
   input  wire logic [15:0]   wr_prev
);

   logic [15:0] older_mem [DEPTH];
   logic [15:0] prev_mem [DEPTH];
   logic [15:0] rd_older_ff;
   logic [15:0] rd_prev_ff;

   // read both rows into registered outputs
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_older_ff <= older_mem[rd_addr];
         rd_prev_ff  <= prev_mem[rd_addr];
      end
   end

   // write back the rolled column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= wr_older;
         prev_mem[wr_addr]  <= wr_prev;
      end
   end

   assign rd_older = rd_older_ff;
   assign rd_prev  = rd_prev_ff;

endmodule
`default_nettype wire

>>> rtl/core/hvn_norm.sv
`default_nettype none
module hvn_norm (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire hvn_pkg::vec_type vec,
   output logic                  done,
   output hvn_pkg::nrm_type      nrm
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SQR   = 3'd1;
   localparam logic [2:0] ST_ROOT  = 3'd2;
   localparam logic [2:0] ST_DLOAD = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]         state_ff;
   logic [3:0]         cnt_ff;
   logic [1:0]         comp_ff;
   logic [16:0]        mag_ff [3];
   logic [2:0]         neg_ff;
   logic [33:0]        prod_ff;
   logic [35:0]        sum_ff;
   logic [63:0]        rad_ff;
   logic [63:0]        root_ff;
   logic [63:0]        bit_ff;
   logic [45:0]        num_ff;
   logic [45:0]        dvs_ff;
   logic [14:0]        quo_ff;
   logic signed [15:0] out_ff [3];

   logic [35:0] sum_in;
   logic [63:0] trial;
   logic        num_ge;
   logic [14:0] quo_in;
   logic [14:0] sat_q;

   always_comb begin
      sum_in = sum_ff + 36'(prod_ff);
      trial  = root_ff + bit_ff;
      num_ge = num_ff >= dvs_ff;
      quo_in = {quo_ff[13:0], num_ge};
      sat_q  = (32'(quo_in) > hvn_pkg::ONE_Q14) ? 15'(hvn_pkg::ONE_Q14) : quo_in;
   end

   // sequence: squares, root, three divisions; a zero vector gives the unit z vector
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  mag_ff[0] <= vec.x[17] ? 17'(-vec.x) : vec.x[16:0];
                  mag_ff[1] <= vec.y[17] ? 17'(-vec.y) : vec.y[16:0];
                  mag_ff[2] <= vec.z[17] ? 17'(-vec.z) : vec.z[16:0];
                  neg_ff    <= {vec.z[17], vec.y[17], vec.x[17]};
                  sum_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= ST_SQR;
               end
            end
            ST_SQR: begin
               if (cnt_ff < 4'd3) begin
                  prod_ff <= mag_ff[cnt_ff[1:0]] * mag_ff[cnt_ff[1:0]];
               end
               if (cnt_ff != 4'd0) begin
                  sum_ff <= sum_in;
               end
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd3) begin
                  rad_ff   <= {sum_in[35:0], 28'd0};
                  root_ff  <= '0;
                  bit_ff   <= 64'd1 << 62;
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (rad_ff >= trial) begin
                  rad_ff  <= rad_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               comp_ff <= '0;
               if (bit_ff[0]) begin
                  state_ff <= ST_DLOAD;
               end
            end
            ST_DLOAD: begin
               if (root_ff == '0) begin
                  out_ff[0] <= '0;
                  out_ff[1] <= '0;
                  out_ff[2] <= 16'(hvn_pkg::ONE_Q14);
                  state_ff  <= ST_DONE;
               end else begin
                  num_ff   <= 46'({mag_ff[comp_ff], 28'd0}) + 46'(root_ff[31:1]);
                  dvs_ff   <= {root_ff[31:0], 14'd0};
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (num_ge) begin
                  num_ff <= num_ff - dvs_ff;
               end
               dvs_ff <= dvs_ff >> 1;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd14) begin
                  out_ff[comp_ff] <= neg_ff[comp_ff] ? -16'(sat_q) : 16'(sat_q);
                  comp_ff <= comp_ff + 2'd1;
                  state_ff <= (comp_ff == 2'd2) ? ST_DONE : ST_DLOAD;
               end
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done  = state_ff == ST_DONE;
   assign nrm.x = out_ff[0];
   assign nrm.y = out_ff[1];
   assign nrm.z = out_ff[2];

endmodule
`default_nettype wire

>>> rtl/core/heightmap_vertex_normals.sv
// Smoothed vertex normals of a square height grid. Heights arrive one word at a
// time in raster order; the normal of vertex (r-1, c-1) leaves after input
// (r, c), the last column also gives (r-1, c), and the last row flushes its own
// vertices, so one input gives zero to four result words, the final one marked
// by last_of_run. The two previous rows sit in a pair of row memories with a
// separate read and write port that are read and written back once per input.
// One shared iterative normalizer (squares, 32-step square root, three 15-step
// divisions) is started once per adjacent triangle and once for the sum, each
// start waiting for the previous use to finish; an input with no result passes
// through accept, load and five emit steps.
// Writing vertices_per_row restarts the grid at row 0, column 0.
`default_nettype none
module heightmap_vertex_normals #(
   parameter int MAX_ROW_VERTICES = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_height,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_normal_x,
   output logic signed [15:0]      rsp_normal_y,
   output logic [14:0]             rsp_normal_z,
   output logic [9:0]              rsp_vertex_column,
   output logic [9:0]              rsp_vertex_row,
   output logic                    rsp_last_of_run,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [10:0]        csr_vertices_per_row
);

   localparam int CW = $clog2(MAX_ROW_VERTICES);
   localparam int NW = CW + 1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LOAD = 4'd1;
   localparam logic [3:0] ST_EMIT = 4'd2;
   localparam logic [3:0] ST_TRI  = 4'd3;
   localparam logic [3:0] ST_TWAIT = 4'd4;
   localparam logic [3:0] ST_FWAIT = 4'd5;
   localparam logic [3:0] ST_OUT  = 4'd6;

   logic [3:0]         state_ff;
   logic [10:0]        csr_ff;
   logic [CW-1:0]      col_ff;
   logic [CW-1:0]      row_ff;
   logic [CW-1:0]      cur_c_ff;
   logic [CW-1:0]      cur_r_ff;
   logic signed [15:0] h_ff;
   logic signed [15:0] win_ff [3][3];
   logic [3:0]         emask_ff;
   logic [2:0]         eidx_ff;
   logic [1:0]         em_cr_ff;
   logic [1:0]         em_cc_ff;
   logic [CW-1:0]      vr_ff;
   logic [CW-1:0]      vc_ff;
   logic [5:0]         tmask_ff;
   logic [2:0]         tidx_ff;
   hvn_pkg::vec_type   acc_ff;
   hvn_pkg::nrm_type   fin_ff;
   logic               rsp_valid_ff;
   hvn_pkg::nrm_type   rsp_nrm_ff;
   logic [CW-1:0]      rsp_col_ff;
   logic [CW-1:0]      rsp_row_ff;
   logic               rsp_last_ff;

   logic [NW-1:0]      n_eff;
   logic               accept;
   logic [NW-1:0]      col_in;
   logic [15:0]        rd_older;
   logic [15:0]        rd_prev;
   logic               nrm_start;
   hvn_pkg::vec_type   nrm_vec;
   hvn_pkg::vec_type   tri_vec;
   logic               nrm_done;
   hvn_pkg::nrm_type   nrm;
   logic [6:0]         tmask_ext;
   logic [1:0]         em_cr_in;
   logic [1:0]         em_cc_in;
   logic [CW-1:0]      vr_in;
   logic [CW-1:0]      vc_in;
   logic [5:0]         tmask_in;
   logic [3:0]         emask_in;
   logic [3:0]         erest;
   logic signed [17:0] nb [3][3];
   logic               out_free;
   logic [31:0]        col_wide;
   logic [31:0]        row_wide;

   // window read, out of range rows or columns read as zero
   function automatic logic signed [17:0] wget(input logic signed [15:0] w [3][3],
                                               input logic [1:0] rr, input logic [1:0] cc);
      logic signed [17:0] val;
      val = '0;
      if (rr != 2'd3 && cc != 2'd3) begin
         val = 18'(w[rr][cc]);
      end
      return val;
   endfunction

   // clamp the grid side
   always_comb begin
      if (csr_ff < 11'd2) begin
         n_eff = NW'(2);
      end else if (32'(csr_ff) > MAX_ROW_VERTICES) begin
         n_eff = NW'(MAX_ROW_VERTICES);
      end else begin
         n_eff = NW'(csr_ff);
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign col_in    = NW'(col_ff) + NW'(1);

   hvn_rowbuf #(
      .DEPTH(MAX_ROW_VERTICES),
      .AW(CW)
   ) u_rowbuf (
      .clock(clock),
      .rd_en(accept),
      .rd_addr(col_ff),
      .rd_older(rd_older),
      .rd_prev(rd_prev),
      .wr_en(state_ff == ST_LOAD),
      .wr_addr(cur_c_ff),
      .wr_older(rd_prev),
      .wr_prev(h_ff)
   );

   // emits of this input and the chosen emit's vertex
   always_comb begin
      emask_in[0] = (cur_r_ff != '0) && (cur_c_ff != '0);
      emask_in[1] = (cur_r_ff != '0) && (NW'(cur_c_ff) == n_eff - NW'(1));
      emask_in[2] = (NW'(cur_r_ff) == n_eff - NW'(1)) && (cur_c_ff != '0);
      emask_in[3] = (NW'(cur_r_ff) == n_eff - NW'(1)) &&
                    (NW'(cur_c_ff) == n_eff - NW'(1));
      em_cr_in = eidx_ff[1] ? 2'd2 : 2'd1;
      em_cc_in = eidx_ff[0] ? 2'd2 : 2'd1;
      vr_in = eidx_ff[1] ? cur_r_ff : cur_r_ff - CW'(1);
      vc_in = eidx_ff[0] ? cur_c_ff : cur_c_ff - CW'(1);
      tmask_in[0] = (NW'(vc_in) + NW'(1) < n_eff) && (NW'(vr_in) + NW'(1) < n_eff);
      tmask_in[1] = (vc_in != '0) && (NW'(vr_in) + NW'(1) < n_eff);
      tmask_in[2] = (vr_in != '0) && (NW'(vc_in) + NW'(1) < n_eff);
      tmask_in[3] = (vc_in != '0) && (vr_in != '0);
      tmask_in[4] = tmask_in[2];
      tmask_in[5] = tmask_in[1];
      erest = emask_ff >> (eidx_ff + 3'd1);
   end

   // gather the 3x3 neighborhood of the current vertex
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            nb[i][j] = wget(win_ff, em_cr_ff + 2'(i) - 2'd1, em_cc_ff + 2'(j) - 2'd1);
         end
      end
   end

   // triangle normal for the current triangle
   always_comb begin
      tri_vec.z = 18'(hvn_pkg::TRI_Z);
      case (tidx_ff)
         3'd0: begin
            tri_vec.x = nb[1][2] - nb[1][1];
            tri_vec.y = nb[2][1] - nb[1][1];
         end
         3'd1: begin
            tri_vec.x = nb[1][1] - nb[1][0];
            tri_vec.y = nb[2][0] - nb[1][0];
         end
         3'd2: begin
            tri_vec.x = nb[0][2] - nb[0][1];
            tri_vec.y = nb[1][1] - nb[0][1];
         end
         3'd3: begin
            tri_vec.x = nb[1][1] - nb[1][0];
            tri_vec.y = nb[1][1] - nb[0][1];
         end
         3'd4: begin
            tri_vec.x = nb[1][2] - nb[1][1];
            tri_vec.y = nb[1][2] - nb[0][2];
         end
         3'd5: begin
            tri_vec.x = nb[2][1] - nb[2][0];
            tri_vec.y = nb[2][1] - nb[1][1];
         end
         default: begin
            tri_vec.x = '0;
            tri_vec.y = '0;
         end
      endcase
   end

   assign tmask_ext = {1'b1, tmask_ff};
   assign nrm_start = (state_ff == ST_TRI) && tmask_ext[tidx_ff];
   assign nrm_vec   = (tidx_ff == 3'd6) ? acc_ff : tri_vec;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   hvn_norm u_norm (
      .clock(clock),
      .reset(reset),
      .start(nrm_start),
      .vec(nrm_vec),
      .done(nrm_done),
      .nrm(nrm)
   );

   // hold the side register; a write restarts the grid
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= 11'd705;
      end else if (csr_valid && csr_ready) begin
         csr_ff <= csr_vertices_per_row;
      end
   end

   // advance the grid position on each accepted word; a side write returns it to row 0, column 0
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_in >= n_eff) begin
            col_ff <= '0;
            row_ff <= (NW'(row_ff) + NW'(1) >= n_eff) ? '0 : row_ff + CW'(1);
         end else begin
            col_ff <= col_in[CW-1:0];
         end
      end
   end

   // shift the window one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (state_ff == ST_LOAD) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= rd_older;
         win_ff[1][2] <= rd_prev;
         win_ff[2][2] <= h_ff;
      end
   end

   // sequence emits and triangles
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  h_ff     <= req_height;
                  cur_c_ff <= col_ff;
                  cur_r_ff <= row_ff;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               emask_ff <= emask_in;
               eidx_ff  <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (eidx_ff == 3'd4) begin
                  state_ff <= ST_IDLE;
               end else if (emask_ff[eidx_ff[1:0]]) begin
                  em_cr_ff <= em_cr_in;
                  em_cc_ff <= em_cc_in;
                  vr_ff    <= vr_in;
                  vc_ff    <= vc_in;
                  tmask_ff <= tmask_in;
                  tidx_ff  <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_TRI;
               end else begin
                  eidx_ff <= eidx_ff + 3'd1;
               end
            end
            ST_TRI: begin
               if (nrm_start) begin
                  state_ff <= (tidx_ff == 3'd6) ? ST_FWAIT : ST_TWAIT;
               end else begin
                  tidx_ff <= tidx_ff + 3'd1;
               end
            end
            ST_TWAIT: begin
               if (nrm_done) begin
                  acc_ff.x <= acc_ff.x + 18'(nrm.x);
                  acc_ff.y <= acc_ff.y + 18'(nrm.y);
                  acc_ff.z <= acc_ff.z + 18'(nrm.z);
                  tidx_ff  <= tidx_ff + 3'd1;
                  state_ff <= ST_TRI;
               end
            end
            ST_FWAIT: begin
               if (nrm_done) begin
                  fin_ff   <= nrm;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  eidx_ff  <= eidx_ff + 3'd1;
                  state_ff <= ST_EMIT;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // output register: load a finished normal, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_nrm_ff  <= fin_ff;
         rsp_col_ff  <= vc_ff;
         rsp_row_ff  <= vr_ff;
         rsp_last_ff <= erest == '0;
      end
   end

   assign col_wide          = 32'(rsp_col_ff);
   assign row_wide          = 32'(rsp_row_ff);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_normal_x      = rsp_nrm_ff.x;
   assign rsp_normal_y      = rsp_nrm_ff.y;
   assign rsp_normal_z      = rsp_nrm_ff.z[14:0];
   assign rsp_vertex_column = col_wide[9:0];
   assign rsp_vertex_row    = row_wide[9:0];
   assign rsp_last_of_run   = rsp_last_ff;

endmodule
`default_nettype wire

>>> rtl/core/hvn_checker.sv
`default_nettype none
module hvn_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic signed [15:0] rsp_normal_x,
   input wire logic signed [15:0] rsp_normal_y,
   input wire logic [14:0]        rsp_normal_z,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall
);

   // a result word waits while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped under stall");

   // one word in flight: input stalls right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while busy");

   // every normal points up
   a_z_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_z != 15'd0)
      else $error("normal z is zero");

   // unit length bounds
   a_xy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384 &&
                     rsp_normal_y <= 16'sd16384 && rsp_normal_y >= -16'sd16384))
      else $error("normal component out of range");

endmodule

bind heightmap_vertex_normals hvn_checker u_hvn_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_normal_x(rsp_normal_x),
   .rsp_normal_y(rsp_normal_y),
   .rsp_normal_z(rsp_normal_z),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall)
);
`default_nettype wire

>>> bench/tb_heightmap_vertex_normals.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_heightmap_vertex_normals;

   localparam int ROW_DEPTH = 1024;
   localparam int RESET_SIDE = 705;
   localparam int HOLD_CYCLES = 3000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES = 2600;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [15:0] req_height;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic [14:0] rsp_normal_z;
   logic [9:0] rsp_vertex_column;
   logic [9:0] rsp_vertex_row;
   logic rsp_last_of_run;
   logic csr_valid;
   logic csr_ready;
   logic [10:0] csr_vertices_per_row;

   heightmap_vertex_normals uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_height(req_height),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z),
      .rsp_vertex_column(rsp_vertex_column),
      .rsp_vertex_row(rsp_vertex_row),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_vertices_per_row(csr_vertices_per_row)
   );

   typedef struct {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [14:0] nz;
      logic [9:0] col;
      logic [9:0] row;
      logic last;
   } normal_word_type;

   typedef struct packed {
      logic do_cfg;
      logic [10:0] side;
      logic [15:0] height;
      logic flat;
   } height_row_type;

   // directed rows: flat 2x2 grid, extremes on 2x2, mixed bit patterns on 3x3
   localparam height_row_type HEIGHT_ROWS [0:16] = '{
      '{1'b1, 11'd2, 16'h0000, 1'b1},
      '{1'b0, 11'd0, 16'h0000, 1'b1},
      '{1'b0, 11'd0, 16'h0000, 1'b1},
      '{1'b0, 11'd0, 16'h0000, 1'b1},
      '{1'b0, 11'd0, 16'h7fff, 1'b0},
      '{1'b0, 11'd0, 16'h8000, 1'b0},
      '{1'b0, 11'd0, 16'h8000, 1'b0},
      '{1'b0, 11'd0, 16'h7fff, 1'b0},
      '{1'b1, 11'd3, 16'h7fff, 1'b0},
      '{1'b0, 11'd0, 16'h8000, 1'b0},
      '{1'b0, 11'd0, 16'h0001, 1'b0},
      '{1'b0, 11'd0, 16'hffff, 1'b0},
      '{1'b0, 11'd0, 16'h0000, 1'b0},
      '{1'b0, 11'd0, 16'h5555, 1'b0},
      '{1'b0, 11'd0, 16'haaaa, 1'b0},
      '{1'b0, 11'd0, 16'h0100, 1'b0},
      '{1'b0, 11'd0, 16'hff00, 1'b0}
   };

   // grid state of the predictor
   logic [15:0] older_row [ROW_DEPTH];
   logic [15:0] prior_row [ROW_DEPTH];
   logic [15:0] window [3][3];
   int unsigned col_at;
   int unsigned row_at;
   int unsigned grid_side;

   normal_word_type pending_normals[$];
   int mismatches;
   bit quiet;
   bit hold_rsp;
   bit hold_done;
   int smooth_base;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bit_at;
      res = 0;
      bit_at = 64'd1 << 62;
      while (bit_at > v) bit_at = bit_at >> 2;
      while (bit_at != 0) begin
         if (v >= res + bit_at) begin
            v = v - (res + bit_at);
            res = (res >> 1) + bit_at;
         end else begin
            res = res >> 1;
         end
         bit_at = bit_at >> 2;
      end
      return res;
   endfunction

   // scale a vector to Q1.14 unit length, round to nearest, saturate
   function automatic void unit_scale(input longint vx, input longint vy, input longint vz,
                                      output longint qx, output longint qy,
                                      output longint qz);
      longint unsigned mx, my, mz, s, r, t;
      mx = (vx < 0) ? -vx : vx;
      my = (vy < 0) ? -vy : vy;
      mz = (vz < 0) ? -vz : vz;
      s = mx * mx + my * my + mz * mz;
      r = int_sqrt(s << 28);
      if (r == 0) begin
         qx = 0;
         qy = 0;
         qz = hvn_pkg::ONE_Q14;
      end else begin
         t = ((mx << 28) + (r >> 1)) / r;
         if (t > hvn_pkg::ONE_Q14) t = hvn_pkg::ONE_Q14;
         qx = (vx < 0) ? -longint'(t) : longint'(t);
         t = ((my << 28) + (r >> 1)) / r;
         if (t > hvn_pkg::ONE_Q14) t = hvn_pkg::ONE_Q14;
         qy = (vy < 0) ? -longint'(t) : longint'(t);
         t = ((mz << 28) + (r >> 1)) / r;
         if (t > hvn_pkg::ONE_Q14) t = hvn_pkg::ONE_Q14;
         qz = (vz < 0) ? -longint'(t) : longint'(t);
      end
   endfunction

   function automatic void add_facet(input longint a, input longint b,
                                     inout longint ax, inout longint ay, inout longint az);
      longint qx, qy, qz;
      unit_scale(a, b, hvn_pkg::TRI_Z, qx, qy, qz);
      ax += qx;
      ay += qy;
      az += qz;
   endfunction

   function automatic longint win_at(input int cr, input int cc, input int dr, input int dc);
      int rr, cl;
      rr = cr + dr;
      cl = cc + dc;
      if (rr < 0 || rr > 2 || cl < 0 || cl > 2) return 0;
      return longint'($signed(window[rr][cl]));
   endfunction

   // smoothed normal of vertex (vr, vc) whose height sits at window[cr][cc]
   function automatic normal_word_type vertex_normal(input int cr, input int cc,
                                                     input int unsigned vr,
                                                     input int unsigned vc,
                                                     input int unsigned n);
      normal_word_type w;
      longint ax, ay, az, qx, qy, qz, h;
      bit lf, rt, up, dn;
      ax = 0;
      ay = 0;
      az = 0;
      lf = vc >= 1;
      rt = vc + 1 < n;
      up = vr >= 1;
      dn = vr + 1 < n;
      h = win_at(cr, cc, 0, 0);
      if (rt && dn) add_facet(win_at(cr, cc, 0, 1) - h, win_at(cr, cc, 1, 0) - h, ax, ay, az);
      if (lf && dn)
         add_facet(h - win_at(cr, cc, 0, -1),
                   win_at(cr, cc, 1, -1) - win_at(cr, cc, 0, -1), ax, ay, az);
      if (up && rt)
         add_facet(win_at(cr, cc, -1, 1) - win_at(cr, cc, -1, 0),
                   h - win_at(cr, cc, -1, 0), ax, ay, az);
      if (lf && up)
         add_facet(h - win_at(cr, cc, 0, -1), h - win_at(cr, cc, -1, 0), ax, ay, az);
      if (up && rt)
         add_facet(win_at(cr, cc, 0, 1) - h,
                   win_at(cr, cc, 0, 1) - win_at(cr, cc, -1, 1), ax, ay, az);
      if (lf && dn)
         add_facet(win_at(cr, cc, 1, 0) - win_at(cr, cc, 1, -1),
                   win_at(cr, cc, 1, 0) - h, ax, ay, az);
      unit_scale(ax, ay, az, qx, qy, qz);
      w.nx = qx[15:0];
      w.ny = qy[15:0];
      w.nz = qz[14:0];
      w.col = vc[9:0];
      w.row = vr[9:0];
      w.last = 1'b0;
      return w;
   endfunction

   // advance the grid by one height and queue the normals it releases
   function automatic void predict_normals(input logic [15:0] h, input bit flat);
      normal_word_type found[$];
      int unsigned n, c, r;
      n = grid_side;
      if (n < 2) n = 2;
      if (n > ROW_DEPTH) n = ROW_DEPTH;
      if (col_at >= n) col_at = 0;
      if (row_at >= n) row_at = 0;
      c = col_at;
      r = row_at;
      for (int i = 0; i < 3; i++) begin
         window[i][0] = window[i][1];
         window[i][1] = window[i][2];
      end
      window[0][2] = older_row[c];
      window[1][2] = prior_row[c];
      window[2][2] = h;
      older_row[c] = prior_row[c];
      prior_row[c] = h;
      if (r >= 1 && c >= 1) found.insert(found.size(), vertex_normal(1, 1, r - 1, c - 1, n));
      if (r >= 1 && c == n - 1) found.insert(found.size(), vertex_normal(1, 2, r - 1, c, n));
      if (r == n - 1 && c >= 1) found.insert(found.size(), vertex_normal(2, 1, r, c - 1, n));
      if (r == n - 1 && c == n - 1) found.insert(found.size(), vertex_normal(2, 2, r, c, n));
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) begin
         // a level grid points straight up everywhere
         if (flat) begin
            found[i].nx = 16'sd0;
            found[i].ny = 16'sd0;
            found[i].nz = 15'(hvn_pkg::ONE_Q14);
         end
         pending_normals.insert(pending_normals.size(), found[i]);
      end
      c++;
      if (c >= n) begin
         c = 0;
         r++;
         if (r >= n) r = 0;
      end
      col_at = c;
      row_at = r;
   endfunction

   // mix of raw noise, smooth terrain and extremes
   function automatic logic [15:0] pick_height();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) return 16'($urandom);
      if (sel < 8) begin
         smooth_base = smooth_base + $signed($urandom_range(0, 1024)) - 512;
         if (smooth_base > 32767) smooth_base = 32767;
         if (smooth_base < -32768) smooth_base = -32768;
         return 16'(smooth_base);
      end
      return ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL heightmap_vertex_normals");
      $finish;
   end

   // check each accepted normal word against the oldest expectation
   always @(posedge clock) begin
      normal_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: normal (%0d %0d %0d) vertex r%0d c%0d",
                        rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_vertex_row,
                        rsp_vertex_column);
         end else begin
            e = pending_normals.pop_front();
            if (rsp_normal_x !== e.nx || rsp_normal_y !== e.ny || rsp_normal_z !== e.nz ||
                rsp_vertex_column !== e.col || rsp_vertex_row !== e.row ||
                rsp_last_of_run !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected (%0d %0d %0d) r%0d c%0d last %0b, %s",
                           e.nx, e.ny, e.nz, e.row, e.col, e.last,
                           $sformatf("got (%0d %0d %0d) r%0d c%0d last %0b",
                                     rsp_normal_x, rsp_normal_y, rsp_normal_z,
                                     rsp_vertex_row, rsp_vertex_column, rsp_last_of_run));
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int unsigned burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_height(input logic [15:0] h, input bit flat);
      req_valid <= 1'b1;
      req_height <= h;
      do @(posedge clock); while (req_stall);
      predict_normals(h, flat);
      // drop valid for a random gap now and then
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write the grid side while the block is idle
   task automatic write_side(input logic [10:0] side);
      wait_drained();
      csr_valid <= 1'b1;
      csr_vertices_per_row <= side;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      grid_side = side;
      col_at = 0;
      row_at = 0;
   endtask

   task automatic run_grid(input logic [10:0] side, input int count, input bit pause_mid);
      write_side(side);
      for (int i = 0; i < count; i++) begin
         // hold the sender until every normal so far has come back
         if (pause_mid && i == count / 2) wait_drained();
         send_height(pick_height(), 1'b0);
      end
   endtask

   initial begin
      mismatches = 0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      hold_done = 1'b0;
      smooth_base = 0;
      grid_side = RESET_SIDE;
      col_at = 0;
      row_at = 0;
      foreach (older_row[i]) begin
         older_row[i] = '0;
         prior_row[i] = '0;
      end
      foreach (window[i, j]) window[i][j] = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_height <= '0;
      csr_valid <= 1'b0;
      csr_vertices_per_row <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset side: no normal within the first row
      for (int i = 0; i < 4; i++) send_height(pick_height(), 1'b0);

      // walk the directed rows
      foreach (HEIGHT_ROWS[i]) begin
         if (HEIGHT_ROWS[i].do_cfg) write_side(HEIGHT_ROWS[i].side);
         send_height(HEIGHT_ROWS[i].height, HEIGHT_ROWS[i].flat);
      end

      // random grids; below 2 acts as 2, write mid grid restarts it
      run_grid(11'd0, 4, 1'b0);
      run_grid(11'd1, 6, 1'b0);
      run_grid(11'd3, 18, 1'b1);
      hold_rsp = 1'b1;
      run_grid(11'd6, 36, 1'b0);
      run_grid(11'd5, 20, 1'b1);
      run_grid(11'd4, 16, 1'b0);

      // last part without idling; oversized side acts as the maximum
      quiet = 1'b1;
      run_grid(11'd2047, 3, 1'b0);
      run_grid(11'd1024, 3, 1'b0);
      run_grid(11'd2, 10, 1'b0);

      req_valid <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_normals.size() == 0) begin
         $display("PASS heightmap_vertex_normals");
      end else begin
         $display("FAIL heightmap_vertex_normals");
      end
      $finish;
   end

endmodule
`default_nettype wire
